// ----- rtl/arrow_outline_vertex_gen_top_macros.svh -----
// Assertion helpers for the RTL (included by avg_back).
`ifndef ARROW_OUTLINE_VERTEX_GEN_TOP_MACROS_SVH
`define ARROW_OUTLINE_VERTEX_GEN_TOP_MACROS_SVH

// Clocked check, off while in reset.
`define AVG_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen.
`define AVG_NEVER(lbl, cond, msg) \
  `AVG_CHK(lbl, !(cond), msg)

`endif

// ----- rtl/avg_pkg.sv -----
`timescale 1ns / 1ps
package avg_pkg;

  localparam int CW     = 24;       // coordinate width
  localparam int QDEPTH = 2;
  localparam int OW     = CW + 4;   // offset width (lx, gx, ex ...)
  localparam int VW     = CW + 8;   // vertex sum width before saturation

  typedef struct packed {
    logic signed [CW-1:0] tail_x;
    logic signed [CW-1:0] tail_y;
    logic signed [CW-1:0] tip_x;
    logic signed [CW-1:0] tip_y;
    logic signed [CW-1:0] shaft_width;
    logic signed [CW-1:0] head_width;
    logic signed [CW-1:0] head_length;
  } avg_in_t;

  typedef struct packed {
    logic [2:0]           vertex_number;
    logic signed [CW-1:0] vertex_x;
    logic signed [CW-1:0] vertex_y;
    logic                 degenerate;
    logic                 last_vertex;
  } avg_out_t;

  typedef struct packed {
    avg_in_t              req;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dy;
    logic                 degen;
  } avg_job_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } avg_div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quot;
  } avg_div_rsp_t;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_SQ   = 11'b000_0000_0010,
    S_SUM  = 11'b000_0000_0100,
    S_SQRT = 11'b000_0000_1000,
    S_DIVX = 11'b000_0001_0000,
    S_DIVY = 11'b000_0010_0000,
    S_HWM  = 11'b000_0100_0000,
    S_HST  = 11'b000_1000_0000,
    S_DIVH = 11'b001_0000_0000,
    S_MUL  = 11'b010_0000_0000,
    S_EMIT = 11'b100_0000_0000
  } avg_state_t;

endpackage

// ----- rtl/arrow_outline_vertex_gen_top.sv -----
`timescale 1ns / 1ps
// Arrow outline vertex generator. Each request (tail, tip, shaft width, head width and
// length) yields seven outline vertices in order, the last flagged, or one empty-shape
// transaction when tip equals tail or a size is not positive. Requests enter a two-deep
// queue, so the input keeps accepting until the queue is full, also while the back end
// works and while a result waits on a stalled output. For a normal request the back end
// runs the bitwise square root, three passes of the shared radix-2 divider (both unit
// components and the scaled head width), six products on the shared multiplier, then
// one vertex per cycle while the output is not stalled; an empty shape skips these steps.
module arrow_outline_vertex_gen_top import avg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  avg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output avg_out_t out_data
);

  avg_job_t     f_job, q_job;
  logic         q_full, q_empty, q_pop;
  avg_div_req_t dreq;
  avg_div_rsp_t drsp;

  assign in_stall = q_full;

  avg_front u_front (
    .in_item (in_data),
    .job     (f_job)
  );

  avg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid && !q_full),
    .push_job (f_job),
    .pop      (q_pop),
    .pop_job  (q_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  avg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  avg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .dreq      (dreq),
    .drsp      (drsp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/avg_front.sv -----
`timescale 1ns / 1ps
module avg_front import avg_pkg::*; (
  input  avg_in_t  in_item,
  output avg_job_t job
);

  logic signed [CW:0] dx, dy;
  logic               bad_size;

  assign dx = {in_item.tip_x[CW-1], in_item.tip_x} - {in_item.tail_x[CW-1], in_item.tail_x};
  assign dy = {in_item.tip_y[CW-1], in_item.tip_y} - {in_item.tail_y[CW-1], in_item.tail_y};

  // sizes must be strictly positive
  assign bad_size = in_item.shaft_width[CW-1] || (in_item.shaft_width == '0) ||
                    in_item.head_width[CW-1]  || (in_item.head_width == '0)  ||
                    in_item.head_length[CW-1] || (in_item.head_length == '0);

  assign job.req   = in_item;
  assign job.dx    = dx;
  assign job.dy    = dy;
  assign job.degen = ((dx == '0) && (dy == '0)) || bad_size;

endmodule

// ----- rtl/avg_queue.sv -----
`timescale 1ns / 1ps
module avg_queue import avg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  avg_job_t push_job,
  input  logic     pop,
  output avg_job_t pop_job,
  output logic     full,
  output logic     empty
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  avg_job_t        mem_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNTW'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ----- rtl/avg_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, 64-bit quotient.
module avg_div import avg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  avg_div_req_t req,
  output avg_div_rsp_t rsp
);

  logic [64:0] rem_r, rem_nxt;
  logic [63:0] quot_r, quot_nxt;
  logic [63:0] den_r, den_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;
  logic        ge;

  assign trial = {rem_r[63:0], quot_r[63]};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quot_nxt = req.num;
      den_nxt  = req.den;
      cnt_nxt  = 7'd64;
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? (trial - {1'b0, den_r}) : trial;
      quot_nxt = {quot_r[62:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// ----- rtl/avg_back.sv -----
`timescale 1ns / 1ps
`include "arrow_outline_vertex_gen_top_macros.svh"
module avg_back import avg_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  input  avg_job_t     q_job,
  output logic         q_pop,
  output avg_div_req_t dreq,
  input  avg_div_rsp_t drsp,
  output logic         out_valid,
  input  logic         out_stall,
  output avg_out_t     out_data
);

  localparam logic signed [VW-1:0] SAT_HI = VW'((64'sd1 <<< (CW - 1)) - 1);
  localparam logic signed [VW-1:0] SAT_LO = -SAT_HI - 1;

  avg_state_t state_r, state_nxt;
  avg_job_t   job_r, job_nxt;
  logic [CW-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic [63:0] sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [63:0] rad_r, rad_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [31:0] len_r, len_nxt, ux_r, ux_nxt, uy_r, uy_nxt;
  logic [31:0] cl_r, cl_nxt, chw_r, chw_nxt;
  logic [63:0] hwm_r, hwm_nxt, prod_r, prod_nxt;
  logic signed [OW-1:0] ofs_r [6];
  logic [2:0]  mk_r, mk_nxt, vcnt_r, vcnt_nxt;
  logic        mph_r, mph_nxt;
  avg_div_req_t dreq_r, dreq_nxt;
  avg_out_t    out_r, out_nxt;
  logic        ov_r, ov_nxt;

  logic [63:0] trial, res_fin;
  logic [31:0] len_fin, hl_u, sw_u, hw_u;
  logic [31:0] mul_a, mul_m;
  logic        mul_sh31, mul_neg;
  logic [63:0] rnd;
  logic signed [OW-1:0] ofs_val;
  logic        load;
  logic signed [VW-1:0] tx, ty, px, py, lx, ly, gx, gy, ex, ey, vx, vy;

  assign hl_u = 32'($unsigned(job_r.req.head_length));
  assign sw_u = 32'($unsigned(job_r.req.shaft_width));
  assign hw_u = 32'($unsigned(job_r.req.head_width));

  // one step of the bitwise integer root
  assign trial   = res_r + bit_r;
  assign res_fin = (rad_r >= trial) ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign len_fin = (res_fin[31:0] == '0) ? 32'd1 : res_fin[31:0];

  // shared multiplier operand select
  always_comb begin
    mul_a = ux_r; mul_m = sw_u; mul_sh31 = 1'b1; mul_neg = !job_r.dx[CW];
    case (mk_r)
      3'd0: begin mul_a = uy_r; mul_m = sw_u;  mul_sh31 = 1'b1; mul_neg = job_r.dy[CW];  end
      3'd1: begin mul_a = ux_r; mul_m = sw_u;  mul_sh31 = 1'b1; mul_neg = !job_r.dx[CW]; end
      3'd2: begin mul_a = ux_r; mul_m = cl_r;  mul_sh31 = 1'b0; mul_neg = job_r.dx[CW];  end
      3'd3: begin mul_a = uy_r; mul_m = cl_r;  mul_sh31 = 1'b0; mul_neg = job_r.dy[CW];  end
      3'd4: begin mul_a = uy_r; mul_m = chw_r; mul_sh31 = 1'b1; mul_neg = job_r.dy[CW];  end
      3'd5: begin mul_a = ux_r; mul_m = chw_r; mul_sh31 = 1'b1; mul_neg = !job_r.dx[CW]; end
      default: ;
    endcase
  end

  // round half away from zero, then apply sign
  assign rnd     = mul_sh31 ? ((prod_r + (64'd1 << 30)) >> 31) : ((prod_r + (64'd1 << 29)) >> 30);
  assign ofs_val = mul_neg ? -OW'(rnd) : OW'(rnd);

  // vertex sums
  assign tx = VW'(job_r.req.tail_x);
  assign ty = VW'(job_r.req.tail_y);
  assign px = VW'(job_r.req.tip_x);
  assign py = VW'(job_r.req.tip_y);
  assign lx = VW'(ofs_r[0]);
  assign ly = VW'(ofs_r[1]);
  assign gx = VW'(ofs_r[2]);
  assign gy = VW'(ofs_r[3]);
  assign ex = VW'(ofs_r[4]);
  assign ey = VW'(ofs_r[5]);

  always_comb begin
    vx = px; vy = py;
    case (vcnt_r)
      3'd0: begin vx = tx + lx;           vy = ty + ly;           end
      3'd1: begin vx = px + lx - gx;      vy = py + ly - gy;      end
      3'd2: begin vx = px + lx - gx + ex; vy = py + ly - gy + ey; end
      3'd3: begin vx = px;                vy = py;                end
      3'd4: begin vx = px - lx - gx - ex; vy = py - ly - gy - ey; end
      3'd5: begin vx = px - lx - gx;      vy = py - ly - gy;      end
      3'd6: begin vx = tx - lx;           vy = ty - ly;           end
      default: ;
    endcase
  end

  function automatic logic signed [CW-1:0] sat(input logic signed [VW-1:0] v);
    if (v > SAT_HI) return CW'(SAT_HI);
    if (v < SAT_LO) return CW'(SAT_LO);
    return CW'(v);
  endfunction

  assign load = (state_r == S_EMIT) && (!ov_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    ax_nxt = ax_r; ay_nxt = ay_r;
    sqx_nxt = sqx_r; sqy_nxt = sqy_r;
    rad_nxt = rad_r; res_nxt = res_r; bit_nxt = bit_r;
    len_nxt = len_r; ux_nxt = ux_r; uy_nxt = uy_r;
    cl_nxt = cl_r; chw_nxt = chw_r; hwm_nxt = hwm_r; prod_nxt = prod_r;
    mk_nxt = mk_r; mph_nxt = mph_r; vcnt_nxt = vcnt_r;
    dreq_nxt = dreq_r;
    dreq_nxt.start = 1'b0;
    out_nxt = out_r;
    ov_nxt  = ov_r && out_stall;
    q_pop   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          job_nxt  = q_job;
          ax_nxt   = CW'(q_job.dx[CW] ? -q_job.dx : q_job.dx);
          ay_nxt   = CW'(q_job.dy[CW] ? -q_job.dy : q_job.dy);
          vcnt_nxt = '0;
          state_nxt = q_job.degen ? S_EMIT : S_SQ;
        end
      end
      S_SQ: begin
        sqx_nxt = 64'(32'(ax_r) * 64'(32'(ax_r)));
        sqy_nxt = 64'(32'(ay_r) * 64'(32'(ay_r)));
        state_nxt = S_SUM;
      end
      S_SUM: begin
        rad_nxt = sqx_r + sqy_r;
        res_nxt = '0;
        bit_nxt = 64'd1 << 62;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (rad_r >= trial) rad_nxt = rad_r - trial;
        res_nxt = res_fin;
        bit_nxt = bit_r >> 2;
        if (bit_r == 64'd1) begin
          len_nxt = len_fin;
          dreq_nxt.start = 1'b1;
          dreq_nxt.num   = (64'(ax_r) << 30) + 64'(len_fin >> 1);
          dreq_nxt.den   = 64'(len_fin);
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        if (drsp.done) begin
          ux_nxt = drsp.quot[31:0];
          dreq_nxt.start = 1'b1;
          dreq_nxt.num   = (64'(ay_r) << 30) + 64'(len_r >> 1);
          dreq_nxt.den   = 64'(len_r);
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        if (drsp.done) begin
          uy_nxt = drsp.quot[31:0];
          cl_nxt = (len_r < hl_u) ? len_r : hl_u;
          state_nxt = S_HWM;
        end
      end
      S_HWM: begin
        hwm_nxt = 64'(hw_u) * 64'(cl_r);
        state_nxt = S_HST;
      end
      S_HST: begin
        dreq_nxt.start = 1'b1;
        dreq_nxt.num   = hwm_r + 64'(hl_u >> 1);
        dreq_nxt.den   = 64'(hl_u);
        state_nxt = S_DIVH;
      end
      S_DIVH: begin
        if (drsp.done) begin
          chw_nxt = drsp.quot[31:0];
          mk_nxt  = '0;
          mph_nxt = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        mph_nxt = !mph_r;
        if (!mph_r) begin
          prod_nxt = 64'(mul_a) * 64'(mul_m);
        end else begin
          mk_nxt = mk_r + 1'b1;
          if (mk_r == 3'd5) begin
            vcnt_nxt  = '0;
            state_nxt = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (load) begin
          ov_nxt = 1'b1;
          if (job_r.degen) begin
            out_nxt.vertex_number = '0;
            out_nxt.vertex_x      = '0;
            out_nxt.vertex_y      = '0;
            out_nxt.degenerate    = 1'b1;
            out_nxt.last_vertex   = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            out_nxt.vertex_number = vcnt_r;
            out_nxt.vertex_x      = sat(vx);
            out_nxt.vertex_y      = sat(vy);
            out_nxt.degenerate    = 1'b0;
            out_nxt.last_vertex   = (vcnt_r == 3'd6);
            vcnt_nxt = (vcnt_r == 3'd6) ? 3'd0 : vcnt_r + 1'b1;
            if (vcnt_r == 3'd6) state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ov_r         <= 1'b0;
      dreq_r.start <= 1'b0;
      vcnt_r       <= '0;
      mk_r         <= '0;
      mph_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ov_r         <= ov_nxt;
      dreq_r.start <= dreq_nxt.start;
      vcnt_r       <= vcnt_nxt;
      mk_r         <= mk_nxt;
      mph_r        <= mph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    ax_r <= ax_nxt;   ay_r <= ay_nxt;
    sqx_r <= sqx_nxt; sqy_r <= sqy_nxt;
    rad_r <= rad_nxt; res_r <= res_nxt; bit_r <= bit_nxt;
    len_r <= len_nxt; ux_r <= ux_nxt; uy_r <= uy_nxt;
    cl_r <= cl_nxt;   chw_r <= chw_nxt;
    hwm_r <= hwm_nxt; prod_r <= prod_nxt;
    dreq_r.num <= dreq_nxt.num;
    dreq_r.den <= dreq_nxt.den;
    out_r <= out_nxt;
    if ((state_r == S_MUL) && mph_r) ofs_r[mk_r] <= ofs_val;
  end

  assign dreq      = dreq_r;
  assign out_valid = ov_r;
  assign out_data  = out_r;

  `AVG_CHK(a_degen_last, (ov_r && out_r.degenerate) |-> out_r.last_vertex, "empty shape not last")
  `AVG_CHK(a_last_six, (ov_r && !out_r.degenerate && out_r.last_vertex) |-> (out_r.vertex_number == 3'd6), "last vertex not 6")
  `AVG_CHK(a_div_start, dreq_r.start |-> (state_r == S_DIVX || state_r == S_DIVY || state_r == S_DIVH), "divider started outside a divide step")
  `AVG_NEVER(a_vcnt_range, vcnt_r > 3'd6, "vertex counter past 6")

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import avg_pkg::*;

  localparam int UNIT = 30;
  localparam int WDOG_LIMIT = 40000;

  // Expected-vertex store; predicts outline vertices from accepted requests.
  class arrow_scoreboard;
    avg_out_t pending[$];
    int errors;

    function automatic longint sat(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function automatic longint rnd_mul(longint u, longint unsigned m, int sh);
      longint unsigned mag, r;
      mag = (u < 0) ? longint'(-u) : longint'(u);
      r = (mag * m + (64'd1 << (sh - 1))) >> sh;
      return (u < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint unsigned root(longint unsigned x);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_request(avg_in_t r);
      longint tx, ty, px, py, sw, hw, hl, dx, dy, lx, ly, gx, gy, ex, ey, ux, uy;
      longint unsigned ax, ay, len, cl, chw;
      longint vx[7], vy[7];
      avg_out_t o;
      tx = r.tail_x; ty = r.tail_y; px = r.tip_x; py = r.tip_y;
      sw = r.shaft_width; hw = r.head_width; hl = r.head_length;
      dx = px - tx; dy = py - ty;
      if ((dx == 0 && dy == 0) || sw <= 0 || hw <= 0 || hl <= 0) begin
        o = '0;
        o.degenerate = 1'b1;
        o.last_vertex = 1'b1;
        pending.push_back(o);
        return;
      end
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      len = root(ax * ax + ay * ay);
      if (len == 0) len = 1;
      ux = ((ax << UNIT) + len / 2) / len;
      uy = ((ay << UNIT) + len / 2) / len;
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
      cl = (len < hl) ? len : hl;
      chw = (hw * cl + hl / 2) / hl;
      lx = rnd_mul(uy, sw, UNIT + 1);
      ly = rnd_mul(-ux, sw, UNIT + 1);
      gx = rnd_mul(ux, cl, UNIT);
      gy = rnd_mul(uy, cl, UNIT);
      ex = rnd_mul(uy, chw, UNIT + 1);
      ey = rnd_mul(-ux, chw, UNIT + 1);
      vx[0] = tx + lx;           vy[0] = ty + ly;
      vx[1] = px + lx - gx;      vy[1] = py + ly - gy;
      vx[2] = vx[1] + ex;        vy[2] = vy[1] + ey;
      vx[3] = px;                vy[3] = py;
      vx[4] = px - lx - gx - ex; vy[4] = py - ly - gy - ey;
      vx[5] = px - lx - gx;      vy[5] = py - ly - gy;
      vx[6] = tx - lx;           vy[6] = ty - ly;
      for (int i = 0; i < 7; i++) begin
        o.vertex_number = 3'(i);
        o.vertex_x = CW'(sat(vx[i]));
        o.vertex_y = CW'(sat(vy[i]));
        o.degenerate = 1'b0;
        o.last_vertex = (i == 6);
        pending.push_back(o);
      end
    endfunction

    function void check_vertex(avg_out_t got);
      avg_out_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected transaction %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.vertex_number !== want.vertex_number || got.vertex_x !== want.vertex_x ||
          got.vertex_y !== want.vertex_y || got.degenerate !== want.degenerate ||
          got.last_vertex !== want.last_vertex) begin
        $display("%0t: mismatch expected %p actual %p", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_valid, in_stall, out_valid, out_stall;
  avg_in_t in_data;
  avg_out_t out_data;
  int send_idle_pct, recv_stall_pct, quiet_cycles;
  arrow_scoreboard vertices;

  arrow_outline_vertex_gen_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) vertices.note_request(in_data);
    if (rst_n && out_valid && !out_stall) vertices.check_vertex(out_data);
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return CW'($urandom_range(4000) - 2000);
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_size();
    case ($urandom_range(9))
      0: return CW'(-$urandom_range(300));
      1: return CW'($urandom);
      2: return {1'b0, {(CW-1){1'b1}}};
      default: return CW'($urandom_range(1, 20000));
    endcase
  endfunction

  task automatic send_request(avg_in_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    avg_in_t r;
    r.tail_x = rand_coord();
    r.tail_y = rand_coord();
    r.tip_x = rand_coord();
    r.tip_y = rand_coord();
    if ($urandom_range(19) == 0) begin
      r.tip_x = r.tail_x;
      r.tip_y = r.tail_y;
    end
    r.shaft_width = rand_size();
    r.head_width = rand_size();
    r.head_length = rand_size();
    send_request(r);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (vertices.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic directed(logic [CW-1:0] tx, ty, px, py, sw, hw, hl);
    avg_in_t r;
    r = '{tx, ty, px, py, sw, hw, hl};
    send_request(r);
  endtask

  localparam logic [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  initial begin
    vertices = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed(0, 0, 2560, 0, 256, 768, 512);
    directed(0, 0, 0, 2560, 256, 768, 512);
    directed(100, 100, 100, 100, 256, 256, 256);     // tip on tail
    directed(0, 0, 1000, 0, 0, 256, 256);            // zero shaft
    directed(0, 0, 1000, 0, 256, -5, 256);           // negative head width
    directed(0, 0, 1000, 0, 256, 256, MINV);         // negative head length
    directed(0, 0, 300, 400, 256, 1000, 4000);       // shorter than head
    directed(MINV, MINV, MAXV, MAXV, MAXV, MAXV, MAXV);
    directed(MAXV, MAXV, MINV, MINV, MAXV, MAXV, 1);
    directed(MAXV, 0, MINV, 0, 1, 1, MAXV);
    directed(-500, 700, 1, -3, 999, 77, 33);
    directed(0, 0, 1, 1, MAXV, MAXV, MAXV);
    directed(0, 0, -1, 0, 3, 3, 3);
    drain();  // sender holds until all vertices are out

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      for (int k = 0; k < 85; k++) send_random();
    end
    recv_stall_pct = 0;
    drain();
    if (vertices.errors == 0 && vertices.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
